>>> sv/npdhc_pkg.sv
package npdhc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SMOOTH = 2'd3;

  // microprogram
  localparam int PC_W = 5;

  // multiplier operand A
  localparam logic [3:0] A_DELTA = 4'd0;
  localparam logic [3:0] A_SR    = 4'd1;
  localparam logic [3:0] A_AE    = 4'd2;
  localparam logic [3:0] A_E2LO  = 4'd3;
  localparam logic [3:0] A_E2HI  = 4'd4;
  localparam logic [3:0] A_ACC   = 4'd5;
  localparam logic [3:0] A_KPLO  = 4'd6;
  localparam logic [3:0] A_KPHI  = 4'd7;
  localparam logic [3:0] A_RGAIN = 4'd8;

  // multiplier operand B
  localparam logic [2:0] B_W     = 3'd0;
  localparam logic [2:0] B_WINV  = 3'd1;
  localparam logic [2:0] B_AE    = 3'd2;
  localparam logic [2:0] B_SG    = 3'd3;
  localparam logic [2:0] B_MAGIC = 3'd4;
  localparam logic [2:0] B_SR    = 3'd5;

  // datapath operations
  localparam logic [4:0] OP_NOP      = 5'd0;
  localparam logic [4:0] OP_PREP     = 5'd1;
  localparam logic [4:0] OP_PRIME    = 5'd2;
  localparam logic [4:0] OP_ACC_LOAD = 5'd3;
  localparam logic [4:0] OP_ACC_ADD  = 5'd4;
  localparam logic [4:0] OP_FILT     = 5'd5;
  localparam logic [4:0] OP_ACC_HI32 = 5'd6;
  localparam logic [4:0] OP_KP_SQ    = 5'd7;
  localparam logic [4:0] OP_BASE5    = 5'd8;
  localparam logic [4:0] OP_KP_CUT   = 5'd9;
  localparam logic [4:0] OP_P_HI     = 5'd10;
  localparam logic [4:0] OP_P_SAT    = 5'd11;
  localparam logic [4:0] OP_PD       = 5'd12;
  localparam logic [4:0] OP_ROUND    = 5'd13;
  localparam logic [4:0] OP_EMIT     = 5'd14;

  // jump conditions
  localparam logic [1:0] J_NONE   = 2'd0;
  localparam logic [1:0] J_PRIME  = 2'd1;
  localparam logic [1:0] J_CUT    = 2'd2;
  localparam logic [1:0] J_ALWAYS = 2'd3;

  // entry points
  localparam logic [PC_W-1:0] PC_CUT   = 5'd9;
  localparam logic [PC_W-1:0] PC_PTERM = 5'd12;
  localparam logic [PC_W-1:0] PC_PRIME = 5'd19;

  typedef struct packed {
    logic [3:0]      a_sel;
    logic [2:0]      b_sel;
    logic [4:0]      op;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
    logic            last;
  } ucode_t;

  typedef struct packed {
    logic prime;
    logic cut;
  } cond_t;

  typedef struct packed {
    ucode_t word;
    logic   fire;
  } ctl_t;

endpackage

>>> sv/npdhc_useq.sv
module npdhc_useq
  import npdhc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  cond_t cond,
  input  logic  hold,
  output ctl_t  ctl,
  output logic  busy
);

  logic [PC_W-1:0] pc;
  logic            running;
  ucode_t          word;
  logic            taken;

  function automatic ucode_t rom(input logic [PC_W-1:0] addr);
    ucode_t u;
    case (addr)
      5'd0:  u = '{A_DELTA, B_W,     OP_PREP,     J_PRIME,  PC_PRIME, 1'b0};
      5'd1:  u = '{A_DELTA, B_W,     OP_NOP,      J_NONE,   5'd0,     1'b0};
      5'd2:  u = '{A_SR,    B_WINV,  OP_ACC_LOAD, J_NONE,   5'd0,     1'b0};
      5'd3:  u = '{A_AE,    B_AE,    OP_ACC_ADD,  J_NONE,   5'd0,     1'b0};
      5'd4:  u = '{A_DELTA, B_W,     OP_FILT,     J_CUT,    PC_CUT,   1'b0};
      5'd5:  u = '{A_E2LO,  B_SG,    OP_NOP,      J_NONE,   5'd0,     1'b0};
      5'd6:  u = '{A_E2HI,  B_SG,    OP_ACC_HI32, J_NONE,   5'd0,     1'b0};
      5'd7:  u = '{A_DELTA, B_W,     OP_ACC_ADD,  J_NONE,   5'd0,     1'b0};
      5'd8:  u = '{A_DELTA, B_W,     OP_KP_SQ,    J_ALWAYS, PC_PTERM, 1'b0};
      5'd9:  u = '{A_DELTA, B_W,     OP_BASE5,    J_NONE,   5'd0,     1'b0};
      5'd10: u = '{A_ACC,   B_MAGIC, OP_NOP,      J_NONE,   5'd0,     1'b0};
      5'd11: u = '{A_DELTA, B_W,     OP_KP_CUT,   J_NONE,   5'd0,     1'b0};
      5'd12: u = '{A_KPLO,  B_AE,    OP_NOP,      J_NONE,   5'd0,     1'b0};
      5'd13: u = '{A_KPHI,  B_AE,    OP_ACC_LOAD, J_NONE,   5'd0,     1'b0};
      5'd14: u = '{A_RGAIN, B_SR,    OP_P_HI,     J_NONE,   5'd0,     1'b0};
      5'd15: u = '{A_DELTA, B_W,     OP_P_SAT,    J_NONE,   5'd0,     1'b0};
      5'd16: u = '{A_DELTA, B_W,     OP_PD,       J_NONE,   5'd0,     1'b0};
      5'd17: u = '{A_DELTA, B_W,     OP_ROUND,    J_NONE,   5'd0,     1'b0};
      5'd18: u = '{A_DELTA, B_W,     OP_EMIT,     J_NONE,   5'd0,     1'b1};
      5'd19: u = '{A_DELTA, B_W,     OP_PRIME,    J_NONE,   5'd0,     1'b1};
      default: u = '{A_DELTA, B_W,   OP_NOP,      J_NONE,   5'd0,     1'b1};
    endcase
    return u;
  endfunction

  assign word = rom(pc);

  always_comb begin
    unique case (word.jmp)
      J_NONE:   taken = 1'b0;
      J_PRIME:  taken = cond.prime;
      J_CUT:    taken = cond.cut;
      J_ALWAYS: taken = 1'b1;
      default:  taken = 1'b0;
    endcase
  end

  // the final step waits for the output register to free up
  assign ctl.word = word;
  assign ctl.fire = running && !(word.last && hold);
  assign busy     = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= '0;
    end else if (start) begin
      running <= 1'b1;
      pc      <= '0;
    end else if (ctl.fire) begin
      if (word.last) begin
        running <= 1'b0;
      end else begin
        pc <= taken ? word.target : pc + PC_W'(1);
      end
    end
  end

endmodule

>>> sv/nonlinear_pd_heading_controller.sv
// Channel   Signals                                         Transfer when
// item      item_valid, item_stall, target_angle,           item_valid && !item_stall
//           measured_angle, vision_error, restart
// result    result_valid, result_stall, correction          result_valid && !result_stall
// config    cfg_wen, cfg_index, cfg_data                    cfg_wen
//
// One item at a time. A tick runs 16 microprogram steps (15 when the vision
// error cuts the gain, 2 on a priming tick) after the cycle it is taken in;
// every step goes through the one shared 33x33 multiplier.
// Synchronous active-high reset; restores register defaults, unprimed.
// The result register lets the next item enter while a result waits; the
// final step holds only while that register is still full and stalled.
module nonlinear_pd_heading_controller
  import npdhc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic signed [23:0]    target_angle,
  input  logic signed [23:0]    measured_angle,
  input  logic signed [15:0]    vision_error,
  input  logic                  restart,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [16:0]    correction
);

  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 56;
  localparam int KP_W     = 48;
  localparam int SQ_SHIFT = 2 * ANGLE_FRAC_BITS - 16;
  localparam logic signed [ACC_W-1:0] LIM     = ACC_W'(64'd12 << ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] P_LIMIT = ACC_W'(64'd1 << 52);
  localparam logic [31:0] MAGIC10 = 32'hCCCC_CCCD;  // x/10 == (x*MAGIC10) >> 35
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // configuration
  logic [23:0] base_gain;
  logic [31:0] square_gain;
  logic [23:0] rate_gain;
  logic [16:0] rate_smoothing;

  // controller state and datapath
  logic signed [23:0]       err_r;
  logic signed [23:0]       last_err;
  logic signed [24:0]       delta_r;
  logic [23:0]              ae_r;
  logic signed [25:0]       sr;
  logic [46:0]              e2_r;
  logic [KP_W-1:0]          kp_r;
  logic signed [49:0]       d_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic                     sat_r;
  logic                     restart_r;
  logic                     cut_r;
  logic                     primed;

  logic               take;
  logic signed [24:0] diff;
  logic signed [23:0] err_in;
  logic [16:0]        w;
  logic [16:0]        w_inv;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] emit_val;
  logic                    emit;

  ctl_t  ctl;
  cond_t cond;
  logic  busy;

  function automatic logic signed [ACC_W-1:0] round16(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] bias;
    // half away from zero: negative values take half minus one, then floor
    bias = x[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768);
    return (x + bias) >>> 16;
  endfunction

  assign take       = item_valid && !item_stall;
  assign item_stall = busy;

  assign diff = 25'(target_angle) - 25'(measured_angle);
  always_comb begin
    if (diff[24] != diff[23]) begin
      err_in = diff[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      err_in = diff[23:0];
    end
  end

  assign w     = (rate_smoothing > ONE_Q16) ? ONE_Q16 : rate_smoothing;
  assign w_inv = ONE_Q16 - w;

  assign cond.prime = !primed || restart_r;
  assign cond.cut   = cut_r;

  npdhc_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (take),
    .cond  (cond),
    .hold  (result_valid && result_stall),
    .ctl   (ctl),
    .busy  (busy)
  );

  always_comb begin
    unique case (ctl.word.a_sel)
      A_DELTA: mul_a = MUL_W'(delta_r);
      A_SR:    mul_a = MUL_W'(sr);
      A_AE:    mul_a = MUL_W'(ae_r);
      A_E2LO:  mul_a = MUL_W'(e2_r[31:0]);
      A_E2HI:  mul_a = MUL_W'(e2_r[46:32]);
      A_ACC:   mul_a = MUL_W'(acc[24:0]);
      A_KPLO:  mul_a = MUL_W'(kp_r[27:0]);
      A_KPHI:  mul_a = MUL_W'(kp_r[KP_W-1:28]);
      A_RGAIN: mul_a = MUL_W'(rate_gain);
      default: mul_a = '0;
    endcase
    unique case (ctl.word.b_sel)
      B_W:     mul_b = MUL_W'(w);
      B_WINV:  mul_b = MUL_W'(w_inv);
      B_AE:    mul_b = MUL_W'(ae_r);
      B_SG:    mul_b = MUL_W'(square_gain);
      B_MAGIC: mul_b = MUL_W'(MAGIC10);
      B_SR:    mul_b = MUL_W'(sr);
      default: mul_b = '0;
    endcase
  end

  assign rnd = round16(acc);

  // output clamp, negation folded into the compare
  always_comb begin
    if (acc > LIM) begin
      emit_val = -LIM;
    end else if (acc < -LIM) begin
      emit_val = LIM;
    end else begin
      emit_val = -acc;
    end
  end

  assign emit = ctl.fire && (ctl.word.op == OP_EMIT || ctl.word.op == OP_PRIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_gain      <= 24'd0;
      square_gain    <= 32'd0;
      rate_gain      <= 24'd1311;
      rate_smoothing <= 17'd52429;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BASE_GAIN:   base_gain      <= cfg_data[23:0];
        REG_SQUARE_GAIN: square_gain    <= cfg_data;
        REG_RATE_GAIN:   rate_gain      <= cfg_data[23:0];
        REG_RATE_SMOOTH: rate_smoothing <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err_r     <= err_in;
      restart_r <= restart;
      cut_r     <= (vision_error >= 16'sd192) || (vision_error <= -16'sd192);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (ctl.fire && ctl.word.op == OP_PRIME) begin
      primed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      unique case (ctl.word.op)
        OP_PREP: begin
          delta_r <= 25'(err_r) - 25'(last_err);
          ae_r    <= err_r[23] ? 24'(-err_r) : 24'(err_r);
        end
        OP_PRIME: begin
          last_err <= err_r;
          sr       <= '0;
        end
        OP_ACC_LOAD: acc <= prod[ACC_W-1:0];
        OP_ACC_ADD:  acc <= acc + $signed(prod[ACC_W-1:0]);
        OP_FILT: begin
          sr       <= rnd[25:0];
          last_err <= err_r;
          e2_r     <= prod[46:0];
        end
        OP_ACC_HI32: acc  <= ACC_W'(prod[63:32]);
        OP_KP_SQ:    kp_r <= KP_W'(base_gain) + KP_W'(acc >>> SQ_SHIFT);
        OP_BASE5:    acc  <= ACC_W'(base_gain) + ACC_W'(5);
        OP_KP_CUT:   kp_r <= KP_W'(prod[PROD_W-1:35]);
        OP_P_HI: begin
          // upper partial product of gain times |error|
          acc   <= acc + ACC_W'({prod[23:0], 28'd0});
          sat_r <= |prod[PROD_W-1:24];
        end
        OP_P_SAT: begin
          if (sat_r || acc > P_LIMIT) begin
            acc <= P_LIMIT;
          end
          d_r <= prod[49:0];
        end
        OP_PD:    acc <= err_r[23] ? ACC_W'(d_r) - acc : ACC_W'(d_r) + acc;
        OP_ROUND: acc <= rnd;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      correction <= (ctl.word.op == OP_PRIME) ? 17'sd0 : emit_val[16:0];
    end
  end

  a_take_holds_off: assert property (@(posedge clk) disable iff (rst)
    take |=> item_stall)
    else $error("item transfer did not block the input");

  a_last_step_emits: assert property (@(posedge clk) disable iff (rst)
    ctl.fire && ctl.word.last |=> result_valid)
    else $error("final step left no result");

  a_primed_sticks: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("controller lost its primed state");

endmodule

>>> tb/sv/tb_nonlinear_pd_heading_controller.sv
`timescale 1ns / 1ps

module tb_nonlinear_pd_heading_controller;
  import npdhc_pkg::*;

  localparam int FRAC = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint unsigned P_CEIL = 64'd1 << 52;
  localparam int DEG = 1 << FRAC;

  typedef struct {
    logic signed [23:0] tgt;
    logic signed [23:0] meas;
    logic signed [15:0] vis;
    logic               rs;
  } heading_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [23:0] target_angle = '0;
  logic signed [23:0] measured_angle = '0;
  logic signed [15:0] vision_error = '0;
  logic restart = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [16:0] correction;

  nonlinear_pd_heading_controller #(.ANGLE_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .target_angle(target_angle), .measured_angle(measured_angle),
    .vision_error(vision_error), .restart(restart),
    .result_valid(result_valid), .result_stall(result_stall),
    .correction(correction)
  );

  always #6 clk = ~clk;

  // controller copy: gains and filter state
  longint unsigned base_gain_r = 0;
  longint unsigned square_gain_r = 0;
  longint unsigned rate_gain_r = 1311;
  longint unsigned rate_smooth_r = 52429;
  longint last_err = 0;
  longint filt_rate = 0;
  bit primed = 1'b0;

  heading_item_t pending_items[$];
  logic signed [16:0] expected_corr[$];
  heading_item_t offered;
  int fails = 0;
  int checked = 0;
  int cycles = 0;
  int send_gap = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  bit calm = 1'b0;

  function automatic longint round_half_away(longint x, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  function automatic logic signed [16:0] predict_correction(heading_item_t it);
    longint err, w, delta, p, d, q, res, lim;
    longint unsigned ae, e2, kp, lo, hi, plo, upper, pu;
    lim = longint'(12) <<< FRAC;
    err = longint'(it.tgt) - longint'(it.meas);
    if (err > 8388607) err = 8388607;
    if (err < -8388608) err = -8388608;
    if (!primed || it.rs) begin
      last_err = err;
      filt_rate = 0;
      primed = 1'b1;
      return '0;
    end
    w = (rate_smooth_r > 65536) ? 65536 : longint'(rate_smooth_r);
    delta = err - last_err;
    filt_rate = round_half_away(delta * w + filt_rate * (65536 - w), 16);
    last_err = err;
    ae = (err < 0) ? longint'(-err) : longint'(err);
    if (it.vis >= 192 || it.vis <= -192) begin
      kp = (base_gain_r + 5) / 10;
    end else begin
      e2 = ae * ae;
      lo = e2 & 64'hFFFF_FFFF;
      hi = e2 >> 32;
      plo = lo * square_gain_r;
      upper = hi * square_gain_r + (plo >> 32);
      kp = base_gain_r + (upper >> (2 * FRAC + 16 - 32));
    end
    if (ae != 0 && kp > P_CEIL / ae) pu = P_CEIL;
    else pu = kp * ae;
    if (pu > P_CEIL) pu = P_CEIL;
    p = (err < 0) ? -longint'(pu) : longint'(pu);
    d = longint'(rate_gain_r) * filt_rate;
    q = round_half_away(p + d, 16);
    res = -q;
    if (res > lim) res = lim;
    if (res < -lim) res = -lim;
    return res[16:0];
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        expected_corr.push_back(predict_correction(offered));
      if (!(item_valid && item_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          offered = pending_items.pop_front();
          target_angle <= offered.tgt;
          measured_angle <= offered.meas;
          vision_error <= offered.vis;
          restart <= offered.rs;
          item_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_corr.size() == 0) begin
          $error("unexpected transfer: correction %0d", correction);
          fails++;
        end else begin
          if (correction !== expected_corr[0]) begin
            $error("correction: expected %0d, actual %0d", expected_corr[0], correction);
            fails++;
          end
          void'(expected_corr.pop_front());
        end
        checked++;
      end
      if (!long_hold_done && checked == 300) begin
        // long back-pressure so the block fills and stalls its input
        long_hold_done = 1'b1;
        hold_left = 400;
        result_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        hold_left = $urandom_range(0, 8);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("nonlinear_pd_heading_controller test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_BASE_GAIN:   base_gain_r = 64'(val[23:0]);
      REG_SQUARE_GAIN: square_gain_r = 64'(val);
      REG_RATE_GAIN:   rate_gain_r = 64'(val[23:0]);
      REG_RATE_SMOOTH: rate_smooth_r = 64'(val[16:0]);
      default: ;
    endcase
  endtask

  task automatic apply_gains(logic [31:0] b, logic [31:0] s, logic [31:0] r, logic [31:0] m);
    write_reg(REG_BASE_GAIN, b);
    write_reg(REG_SQUARE_GAIN, s);
    write_reg(REG_RATE_GAIN, r);
    write_reg(REG_RATE_SMOOTH, m);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_corr.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_item(int t, int m, int v, bit r);
    heading_item_t it;
    it.tgt = 24'(t);
    it.meas = 24'(m);
    it.vis = 16'(v);
    it.rs = r;
    pending_items.push_back(it);
  endtask

  task automatic push_directed();
    add_item(0, 0, 0, 0);
    add_item(8388607, -8388608, 0, 0);
    add_item(-8388608, 8388607, 0, 0);
    add_item(10 * DEG, 10 * DEG, 0, 0);
    add_item(2 * DEG, 0, 191, 0);
    add_item(2 * DEG, 0, 192, 0);
    add_item(-3 * DEG, 0, -192, 0);
    add_item(-3 * DEG, 0, -191, 0);
    add_item(DEG, 0, 32767, 0);
    add_item(DEG, 0, -32768, 0);
    add_item(5 * DEG, -7 * DEG, 0, 1);
    add_item(1, 0, 0, 0);
    add_item(-1, 0, 0, 0);
  endtask

  function automatic heading_item_t random_heading_item();
    heading_item_t it;
    int meas, err, sc, pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.tgt = 24'($urandom);
      it.meas = 24'($urandom);
    end else begin
      // plausible headings with an error of varied scale
      sc = 8 + 3 * $urandom_range(0, 3);
      meas = $urandom_range(0, 360 * DEG) - 180 * DEG;
      err = $urandom_range(0, 2 << sc) - (1 << sc);
      it.meas = 24'(meas);
      it.tgt = 24'(meas + err);
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) it.vis = 16'($urandom_range(0, 382) - 191);
    else if (pick < 85) it.vis = 16'(($urandom_range(0, 1) ? 1 : -1) * $urandom_range(190, 194));
    else it.vis = 16'($urandom);
    it.rs = ($urandom_range(0, 19) == 0);
    return it;
  endfunction

  task automatic run_phase(int n, logic [31:0] b, logic [31:0] s, logic [31:0] r,
                           logic [31:0] m);
    apply_gains(b, s, r, m);
    repeat (n) pending_items.push_back(random_heading_item());
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset gains first, then a moderate set
    push_directed();
    drain();
    apply_gains(2 << 16, 1 << 26, 3 << 16, 32768);
    push_directed();
    drain();
    run_phase(130, 0, 0, 0, 0);
    run_phase(130, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(130, 1 << 16, 0, 1311, 65536);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) calm = 1'b1;
      run_phase(130, $urandom_range(0, 4 << 16), $urandom >> $urandom_range(0, 24),
                $urandom_range(0, 1 << 17), $urandom_range(0, 65536));
    end
    repeat (40) @(posedge clk);
    if (fails == 0)
      $display("nonlinear_pd_heading_controller test passed");
    else
      $display("nonlinear_pd_heading_controller test failed");
    $finish;
  end

endmodule
